// File: hw/rtl/heading_velocity_command_limiter_top_assert.svh
// Assertion macros shared by the limiter RTL.
`ifndef HEADING_VELOCITY_COMMAND_LIMITER_TOP_ASSERT_SVH
`define HEADING_VELOCITY_COMMAND_LIMITER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HVCL_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("hvcl assertion failed");
`define HVCL_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("hvcl assertion failed");
`else
`define HVCL_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define HVCL_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: hw/rtl/hvcl_pkg.sv
package hvcl_pkg;

	localparam int VEL_W   = 14;
	localparam int YR_W    = 15;
	localparam int ANG_W   = 16;
	localparam int LSTEP_W = 13;
	localparam int RSTEP_W = 14;
	localparam int TP_W    = 16;
	localparam int PADDR_W = 4;

	localparam int CORDIC_STEPS = 16;
	localparam int MAX_TABLE    = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < MAX_TABLE) ? CORDIC_STEPS : MAX_TABLE;
	localparam int IDX_W        = 5;
	localparam int CW           = 32;
	localparam int ZW           = 28;

	localparam int N2_W   = 28;
	localparam int ROOT_W = 14;
	localparam int REM_W  = 18;
	localparam int MUL_W  = 18;
	localparam int PROD_W = 36;

	localparam logic signed [ZW-1:0] PI_Z      = 28'sd52707179;
	localparam logic signed [ZW-1:0] HALF_PI_Z = 28'sd26353590;
	localparam logic signed [17:0]   PI_Q13     = 18'sd25736;
	localparam logic signed [17:0]   TWO_PI_Q13 = 18'sd51472;
	localparam logic [16:0]          GAIN_Q16   = 17'd39797;
	localparam logic signed [YR_W-1:0] YR_LIM   = 15'sd8192;
	localparam logic [N2_W-1:0]      SPEED_SQ_LIM = 28'd16777216;

	localparam logic [1:0] REG_MAX_LINEAR_STEP   = 2'd0;
	localparam logic [1:0] REG_MAX_YAW_RATE_STEP = 2'd1;
	localparam logic [1:0] REG_TICK_PERIOD       = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ_F, ST_SQ_L, ST_SCREEN, ST_DIFF, ST_SQ_DX, ST_SQ_DY,
		ST_SQ_STEP, ST_CMP, ST_SQRT, ST_MUL_X, ST_DIV_X_GO, ST_DIV_X,
		ST_DIV_Y_GO, ST_DIV_Y, ST_APPLY, ST_YAW_MUL, ST_YAW, ST_GAIN_X,
		ST_GAIN_Y, ST_ROT_GO, ST_ROT
	} state_t;

	typedef enum logic {ITER_SQRT, ITER_DIV} iter_op_t;

	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_req_t;

	// arctan(2^-i) in radians * 2^24
	function automatic logic signed [ZW-1:0] atan_z(input logic [IDX_W-1:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:  v = 28'sd13176795;
			5'd1:  v = 28'sd7778716;
			5'd2:  v = 28'sd4110060;
			5'd3:  v = 28'sd2086331;
			5'd4:  v = 28'sd1047214;
			5'd5:  v = 28'sd524117;
			5'd6:  v = 28'sd262123;
			5'd7:  v = 28'sd131069;
			5'd8:  v = 28'sd65536;
			5'd9:  v = 28'sd32768;
			5'd10: v = 28'sd16384;
			5'd11: v = 28'sd8192;
			5'd12: v = 28'sd4096;
			5'd13: v = 28'sd2048;
			5'd14: v = 28'sd1024;
			5'd15: v = 28'sd512;
			5'd16: v = 28'sd256;
			5'd17: v = 28'sd128;
			5'd18: v = 28'sd64;
			5'd19: v = 28'sd32;
			5'd20: v = 28'sd16;
			5'd21: v = 28'sd8;
			5'd22: v = 28'sd4;
			5'd23: v = 28'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/hvcl_if.sv
interface hvcl_in_if;
	import hvcl_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] forward_target;
	logic signed [VEL_W-1:0] lateral_target;
	logic signed [YR_W-1:0]  yaw_rate_target;
	logic signed [ANG_W-1:0] measured_yaw;
	logic signed [ANG_W-1:0] initial_yaw;
	logic                    desired_valid;
	modport source (output valid, forward_target, lateral_target, yaw_rate_target,
		measured_yaw, initial_yaw, desired_valid, input ready);
	modport sink (input valid, forward_target, lateral_target, yaw_rate_target,
		measured_yaw, initial_yaw, desired_valid, output ready);
endinterface

interface hvcl_out_if;
	import hvcl_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] world_vel_x;
	logic signed [VEL_W-1:0] world_vel_y;
	logic signed [ANG_W-1:0] yaw_command;
	logic signed [YR_W-1:0]  yaw_rate_command;
	logic                    target_rejected;
	logic                    command_valid;
	modport source (output valid, world_vel_x, world_vel_y, yaw_command,
		yaw_rate_command, target_rejected, command_valid, input ready);
	modport sink (input valid, world_vel_x, world_vel_y, yaw_command,
		yaw_rate_command, target_rejected, command_valid, output ready);
endinterface

// File: hw/rtl/hvcl_iter.sv
module hvcl_iter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hvcl_pkg::iter_req_t        req,
	input  logic [hvcl_pkg::N2_W-1:0]  opnd,
	input  logic [hvcl_pkg::ROOT_W-1:0] divisor,
	output logic                       busy,
	output logic [hvcl_pkg::ROOT_W-1:0] result
);
	import hvcl_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	iter_op_t           op_q;
	logic [N2_W-1:0]    src_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  res_q;
	logic [ROOT_W-1:0]  dvs_q;
	logic [REM_W-1:0]   shifted;
	logic [REM_W-1:0]   trial;
	logic [REM_W:0]     diff;
	logic               take;

	// square root brings down two bits a step, division one
	always_comb begin
		if (op_q == ITER_SQRT) begin
			shifted = {rem_q[REM_W-3:0], src_q[N2_W-1:N2_W-2]};
			trial   = {{(REM_W-ROOT_W-2){1'b0}}, res_q, 2'b01};
		end else begin
			shifted = {rem_q[REM_W-2:0], src_q[N2_W-1]};
			trial   = {{(REM_W-ROOT_W){1'b0}}, dvs_q};
		end
		diff = {1'b0, shifted} - {1'b0, trial};
		take = !diff[REM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(ROOT_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			res_q <= '0;
			dvs_q <= divisor;
			if (req.op == ITER_SQRT) begin
				rem_q <= '0;
				src_q <= opnd;
			end else begin
				rem_q <= REM_W'(opnd[N2_W-1:ROOT_W]);
				src_q <= {opnd[ROOT_W-1:0], {(N2_W-ROOT_W){1'b0}}};
			end
		end else if (busy_q) begin
			rem_q <= take ? diff[REM_W-1:0] : shifted;
			res_q <= {res_q[ROOT_W-2:0], take};
			src_q <= (op_q == ITER_SQRT) ? (src_q << 2) : (src_q << 1);
		end
	end

	assign busy   = busy_q;
	// round the root up when anything is left over
	assign result = (op_q == ITER_SQRT && rem_q != '0) ? res_q + 1'b1 : res_q;

endmodule

// File: hw/rtl/hvcl_cordic.sv
module hvcl_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [hvcl_pkg::CW-1:0]    x_in,
	input  logic signed [hvcl_pkg::CW-1:0]    y_in,
	input  logic signed [hvcl_pkg::ANG_W-1:0] yaw,
	output logic                              busy,
	output logic signed [hvcl_pkg::VEL_W-1:0] vel_x,
	output logic signed [hvcl_pkg::VEL_W-1:0] vel_y
);
	import hvcl_pkg::*;

	logic                    busy_q;
	logic [IDX_W-1:0]        cnt_q;
	logic signed [CW-1:0]    x_q;
	logic signed [CW-1:0]    y_q;
	logic signed [ZW-1:0]    z_q;
	logic signed [ZW-1:0]    z0;
	logic signed [CW-1:0]    xs;
	logic signed [CW-1:0]    ys;
	logic signed [ZW-1:0]    ang;

	function automatic logic signed [VEL_W-1:0] round_sat(input logic signed [CW-1:0] v);
		logic signed [CW:0] r;
		r = (CW+1)'(v) + (CW+1)'(32768);
		r = r >>> 16;
		if (r > (CW+1)'(8191))
			return VEL_W'(8191);
		else if (r < -(CW+1)'(8192))
			return VEL_W'(-8192);
		return r[VEL_W-1:0];
	endfunction

	assign z0  = {{(ZW-ANG_W-11){yaw[ANG_W-1]}}, yaw, 11'b0};
	assign xs  = x_q >>> cnt_q;
	assign ys  = y_q >>> cnt_q;
	assign ang = atan_z(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == IDX_W'(CORDIC_ITERS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// fold by half a turn so the rotation stays within a quarter turn
			if (z0 > HALF_PI_Z) begin
				z_q <= z0 - PI_Z;
				x_q <= -x_in;
				y_q <= -y_in;
			end else if (z0 < -HALF_PI_Z) begin
				z_q <= z0 + PI_Z;
				x_q <= -x_in;
				y_q <= -y_in;
			end else begin
				z_q <= z0;
				x_q <= x_in;
				y_q <= y_in;
			end
		end else if (busy_q) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end
		end
	end

	assign busy  = busy_q;
	assign vel_x = round_sat(x_q);
	assign vel_y = round_sat(y_q);

endmodule

// File: hw/rtl/heading_velocity_command_limiter_top.sv
// A request whose velocity step is within its limit skips the vector cap; otherwise the cap runs
// the shared square-root/divide unit three times.
// The rotation uses a 16-step CORDIC and the cap a 14-step shift-subtract unit.
// Requests are taken one at a time; a result held in the output register
// does not block accept, but the next result waits in the rotator until that one drains.
// Reset clears all held targets, commands, the yaw-loaded flag and restores register defaults.
`include "heading_velocity_command_limiter_top_assert.svh"
module heading_velocity_command_limiter_top (
	input  logic                         clk,
	input  logic                         arst_n,
	hvcl_in_if.sink                      cmd_in,
	hvcl_out_if.source                   cmd_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hvcl_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import hvcl_pkg::*;

	state_t state_q, state_d;

	logic [LSTEP_W-1:0] lin_step_q;
	logic [RSTEP_W-1:0] yr_step_q;
	logic [TP_W-1:0]    tp_q;

	logic signed [VEL_W-1:0] in_f_q, in_l_q;
	logic signed [YR_W-1:0]  in_yr_q;
	logic signed [ANG_W-1:0] meas_q, init_q;
	logic                    valid_q;

	logic signed [VEL_W-1:0] held_f_q, held_l_q, cmd_f_q, cmd_l_q;
	logic signed [YR_W-1:0]  held_yr_q, cmd_yr_q;
	logic signed [ANG_W-1:0] cmd_yaw_q;
	logic                    yaw_loaded_q;

	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [VEL_W+1:0]  dx_q, dy_q, sx_q, sy_q;
	logic [VEL_W-1:0]         adx, ady;
	logic [N2_W-1:0]          n2_q, sq_sum;
	logic [ROOT_W-1:0]        n_q;
	logic                     rej_q, reject;
	logic signed [CW-1:0]     gx_q;
	logic signed [17:0]       rel, rel_q;
	logic signed [16:0]       dr_raw, lim, dr;
	logic signed [19:0]       inc, yaw_sum;
	logic signed [PROD_W-1:0] inc_full;

	iter_req_t         iter_req;
	logic [N2_W-1:0]   iter_opnd;
	logic              iter_busy;
	logic [ROOT_W-1:0] iter_res;
	logic              rot_start, rot_busy;
	logic signed [VEL_W-1:0] rot_x, rot_y;
	logic              out_load;

	logic signed [VEL_W-1:0] out_x_q, out_y_q;
	logic signed [ANG_W-1:0] out_yaw_q;
	logic signed [YR_W-1:0]  out_yr_q;
	logic                    out_rej_q, out_cv_q, out_valid_q;

	hvcl_iter u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (iter_req),
		.opnd    (iter_opnd),
		.divisor (n_q),
		.busy    (iter_busy),
		.result  (iter_res)
	);

	hvcl_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rot_start),
		.x_in   (gx_q),
		.y_in   (prod_q[CW-1:0]),
		.yaw    (cmd_yaw_q),
		.busy   (rot_busy),
		.vel_x  (rot_x),
		.vel_y  (rot_y)
	);

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_step_q <= LSTEP_W'(8);
			yr_step_q  <= RSTEP_W'(16);
			tp_q       <= TP_W'(131);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_MAX_LINEAR_STEP:   lin_step_q <= pwdata[LSTEP_W-1:0];
				REG_MAX_YAW_RATE_STEP: yr_step_q  <= pwdata[RSTEP_W-1:0];
				REG_TICK_PERIOD:       tp_q       <= pwdata[TP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MAX_LINEAR_STEP:   prdata = 32'(lin_step_q);
			REG_MAX_YAW_RATE_STEP: prdata = 32'(yr_step_q);
			REG_TICK_PERIOD:       prdata = 32'(tp_q);
			default:               prdata = '0;
		endcase
	end

	// datapath helpers
	assign adx    = dx_q[VEL_W+1] ? VEL_W'(-dx_q) : VEL_W'(dx_q);
	assign ady    = dy_q[VEL_W+1] ? VEL_W'(-dy_q) : VEL_W'(dy_q);
	assign sq_sum = N2_W'(acc_q) + N2_W'(prod_q);
	assign reject = (sq_sum > SPEED_SQ_LIM) || (in_yr_q > YR_LIM) || (in_yr_q < -YR_LIM);

	always_comb begin
		dr_raw = 17'(held_yr_q) - 17'(cmd_yr_q);
		lim    = signed'(17'(yr_step_q));
		if (dr_raw > lim)
			dr = lim;
		else if (dr_raw < -lim)
			dr = -lim;
		else
			dr = dr_raw;
		rel = 18'(cmd_yaw_q) - 18'(meas_q);
		if (rel > PI_Q13)
			rel = rel - TWO_PI_Q13;
		else if (rel <= -PI_Q13)
			rel = rel + TWO_PI_Q13;
		inc_full = (prod_q + PROD_W'(16384)) >>> 15;
		inc      = inc_full[19:0];
		yaw_sum  = 20'(meas_q) + 20'(rel_q) + inc;
	end

	assign out_load = (state_q == ST_ROT) && !rot_busy && (!out_valid_q || cmd_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		mul_a        = '0;
		mul_b        = '0;
		iter_req     = '{start: 1'b0, op: ITER_DIV};
		iter_opnd    = N2_W'(prod_q);
		rot_start    = 1'b0;
		cmd_in.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_in.ready = 1'b1;
				if (cmd_in.valid)
					state_d = ST_SQ_F;
			end
			ST_SQ_F: begin
				mul_a   = MUL_W'(in_f_q);
				mul_b   = MUL_W'(in_f_q);
				state_d = ST_SQ_L;
			end
			ST_SQ_L: begin
				mul_a   = MUL_W'(in_l_q);
				mul_b   = MUL_W'(in_l_q);
				state_d = ST_SCREEN;
			end
			ST_SCREEN:  state_d = ST_DIFF;
			ST_DIFF:    state_d = ST_SQ_DX;
			ST_SQ_DX: begin
				mul_a   = MUL_W'(dx_q);
				mul_b   = MUL_W'(dx_q);
				state_d = ST_SQ_DY;
			end
			ST_SQ_DY: begin
				mul_a   = MUL_W'(dy_q);
				mul_b   = MUL_W'(dy_q);
				state_d = ST_SQ_STEP;
			end
			ST_SQ_STEP: begin
				mul_a   = signed'(MUL_W'(lin_step_q));
				mul_b   = signed'(MUL_W'(lin_step_q));
				state_d = ST_CMP;
			end
			ST_CMP: begin
				iter_opnd = n2_q;
				if (n2_q > N2_W'(prod_q)) begin
					iter_req = '{start: 1'b1, op: ITER_SQRT};
					state_d  = ST_SQRT;
				end else begin
					state_d  = ST_APPLY;
				end
			end
			ST_SQRT: begin
				if (!iter_busy)
					state_d = ST_MUL_X;
			end
			ST_MUL_X: begin
				mul_a   = signed'(MUL_W'(adx));
				mul_b   = signed'(MUL_W'(lin_step_q));
				state_d = ST_DIV_X_GO;
			end
			ST_DIV_X_GO: begin
				iter_req = '{start: 1'b1, op: ITER_DIV};
				mul_a    = signed'(MUL_W'(ady));
				mul_b    = signed'(MUL_W'(lin_step_q));
				state_d  = ST_DIV_X;
			end
			ST_DIV_X: begin
				mul_a = signed'(MUL_W'(ady));
				mul_b = signed'(MUL_W'(lin_step_q));
				if (!iter_busy)
					state_d = ST_DIV_Y_GO;
			end
			ST_DIV_Y_GO: begin
				iter_req = '{start: 1'b1, op: ITER_DIV};
				state_d  = ST_DIV_Y;
			end
			ST_DIV_Y: begin
				if (!iter_busy)
					state_d = ST_APPLY;
			end
			ST_APPLY:   state_d = ST_YAW_MUL;
			ST_YAW_MUL: begin
				mul_a   = MUL_W'(cmd_yr_q);
				mul_b   = signed'(MUL_W'(tp_q));
				state_d = ST_YAW;
			end
			ST_YAW:     state_d = ST_GAIN_X;
			ST_GAIN_X: begin
				mul_a   = MUL_W'(cmd_f_q);
				mul_b   = signed'(MUL_W'(GAIN_Q16));
				state_d = ST_GAIN_Y;
			end
			ST_GAIN_Y: begin
				mul_a   = MUL_W'(cmd_l_q);
				mul_b   = signed'(MUL_W'(GAIN_Q16));
				state_d = ST_ROT_GO;
			end
			ST_ROT_GO: begin
				rot_start = 1'b1;
				state_d   = ST_ROT;
			end
			ST_ROT: begin
				// hold the finished rotation until the output slot is free
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// shared multiplier
	always_ff @(posedge clk)
		prod_q <= mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_in.valid) begin
			in_f_q  <= cmd_in.forward_target;
			in_l_q  <= cmd_in.lateral_target;
			in_yr_q <= cmd_in.yaw_rate_target;
			meas_q  <= cmd_in.measured_yaw;
			init_q  <= cmd_in.initial_yaw;
			valid_q <= cmd_in.desired_valid;
		end
		if (state_q == ST_SQ_L || state_q == ST_SQ_DY)
			acc_q <= prod_q;
		if (state_q == ST_SCREEN)
			rej_q <= reject;
		if (state_q == ST_DIFF) begin
			dx_q <= (VEL_W+2)'(held_f_q) - (VEL_W+2)'(cmd_f_q);
			dy_q <= (VEL_W+2)'(held_l_q) - (VEL_W+2)'(cmd_l_q);
		end
		if (state_q == ST_SQ_STEP)
			n2_q <= sq_sum;
		if (state_q == ST_CMP) begin
			sx_q <= dx_q;
			sy_q <= dy_q;
		end
		if (state_q == ST_SQRT && !iter_busy)
			n_q <= iter_res;
		if (state_q == ST_DIV_X && !iter_busy)
			sx_q <= dx_q[VEL_W+1] ? -(VEL_W+2)'(iter_res) : (VEL_W+2)'(iter_res);
		if (state_q == ST_DIV_Y && !iter_busy)
			sy_q <= dy_q[VEL_W+1] ? -(VEL_W+2)'(iter_res) : (VEL_W+2)'(iter_res);
		if (state_q == ST_YAW_MUL)
			rel_q <= rel;
		if (state_q == ST_GAIN_Y)
			gx_q <= prod_q[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_f_q     <= '0;
			held_l_q     <= '0;
			held_yr_q    <= '0;
			cmd_f_q      <= '0;
			cmd_l_q      <= '0;
			cmd_yr_q     <= '0;
			cmd_yaw_q    <= '0;
			yaw_loaded_q <= 1'b0;
		end else begin
			if (state_q == ST_SCREEN) begin
				if (!reject) begin
					held_f_q  <= in_f_q;
					held_l_q  <= in_l_q;
					held_yr_q <= in_yr_q;
				end
				if (!yaw_loaded_q) begin
					cmd_yaw_q    <= init_q;
					yaw_loaded_q <= 1'b1;
				end
			end
			if (state_q == ST_APPLY) begin
				cmd_f_q  <= cmd_f_q + VEL_W'(sx_q);
				cmd_l_q  <= cmd_l_q + VEL_W'(sy_q);
				cmd_yr_q <= cmd_yr_q + YR_W'(dr);
			end
			if (state_q == ST_YAW) begin
				if (yaw_sum > 20'sd32767)
					cmd_yaw_q <= 16'sh7FFF;
				else if (yaw_sum < -20'sd32768)
					cmd_yaw_q <= 16'sh8000;
				else
					cmd_yaw_q <= yaw_sum[ANG_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (cmd_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q   <= rot_x;
			out_y_q   <= rot_y;
			out_yaw_q <= cmd_yaw_q;
			out_yr_q  <= cmd_yr_q;
			out_rej_q <= rej_q;
			out_cv_q  <= valid_q;
		end
	end

	assign cmd_out.valid            = out_valid_q;
	assign cmd_out.world_vel_x      = out_x_q;
	assign cmd_out.world_vel_y      = out_y_q;
	assign cmd_out.yaw_command      = out_yaw_q;
	assign cmd_out.yaw_rate_command = out_yr_q;
	assign cmd_out.target_rejected  = out_rej_q;
	assign cmd_out.command_valid    = out_cv_q;

	`HVCL_ASSERT_NXT(a_rot_started, clk, arst_n, state_q == ST_ROT_GO, rot_busy)
	`HVCL_ASSERT_NXT(a_held_taken, clk, arst_n, state_q == ST_SCREEN && !reject, held_f_q == $past(in_f_q) && held_yr_q == $past(in_yr_q))
	`HVCL_ASSERT_IMP(a_yr_range, clk, arst_n, 1'b1, cmd_yr_q <= YR_LIM && cmd_yr_q >= -YR_LIM)
	`HVCL_ASSERT_NXT(a_rot_stall, clk, arst_n, state_q == ST_ROT && out_valid_q && !cmd_out.ready, state_q == ST_ROT)

endmodule

// File: tb/heading_velocity_command_limiter_top_test.sv
module heading_velocity_command_limiter_top_test;
	import hvcl_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 1700;
	localparam int DRAIN_CYCLES   = 120;

	typedef struct packed {
		logic signed [VEL_W-1:0] fwd;
		logic signed [VEL_W-1:0] lat;
		logic signed [YR_W-1:0]  yr;
		logic signed [ANG_W-1:0] meas;
		logic signed [ANG_W-1:0] init;
		logic                    dv;
	} request_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic signed [ANG_W-1:0] yaw;
		logic signed [YR_W-1:0]  yr;
		logic                    rej;
		logic                    cv;
	} command_t;

	typedef struct {
		request_t req;
		logic     known;
		command_t cmd;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	hvcl_in_if  cmd_in ();
	hvcl_out_if cmd_out ();

	heading_velocity_command_limiter_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_in  (cmd_in.sink),
		.cmd_out (cmd_out.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// limiter state copy
	longint lin_step, rate_step, period;
	longint held_f, held_l, held_r, vel_f, vel_l, rate, yaw;
	bit     yaw_ready;

	command_t expected_commands[$];
	int  mismatches;
	int  idle_cycles;
	bit  timed_out;
	int  send_idle_pct, recv_stall_pct;
	bit  hold_off;

	longint atan_z_tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
		262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint root_up(longint n);
		longint r;
		r = 0;
		for (int b = 30; b >= 0; b--)
			if ((r | (64'sd1 << b)) * (r | (64'sd1 << b)) <= n)
				r = r | (64'sd1 << b);
		if (r * r < n)
			r++;
		return r;
	endfunction

	function automatic longint cap_component(longint d, longint s, longint n);
		longint m;
		m = (d < 0 ? -d : d) * s / n;
		return d < 0 ? -m : m;
	endfunction

	function automatic command_t limit_command(request_t r);
		command_t c;
		longint f, l, y, dx, dy, n2, n, dr, rel, x, yv, z, xs, ys;
		bit rej;
		f = longint'(r.fwd);
		l = longint'(r.lat);
		y = longint'(r.yr);
		rej = (f * f + l * l > 16777216) || y > 8192 || y < -8192;
		if (!rej) begin
			held_f = f;
			held_l = l;
			held_r = y;
		end
		if (!yaw_ready) begin
			yaw = longint'(r.init);
			yaw_ready = 1;
		end
		dx = held_f - vel_f;
		dy = held_l - vel_l;
		n2 = dx * dx + dy * dy;
		if (n2 > lin_step * lin_step) begin
			n = root_up(n2);
			dx = cap_component(dx, lin_step, n);
			dy = cap_component(dy, lin_step, n);
		end
		vel_f += dx;
		vel_l += dy;
		dr = clip(held_r - rate, -rate_step, rate_step);
		rate += dr;
		rel = yaw - longint'(r.meas);
		while (rel > 25736)
			rel -= 51472;
		while (rel <= -25736)
			rel += 51472;
		yaw = clip(longint'(r.meas) + rel + floor_shift(rate * period + 16384, 15),
			-32768, 32767);
		x = vel_f * 39797;
		yv = vel_l * 39797;
		z = yaw * 2048;
		if (z > 26353590) begin
			z -= 52707179;
			x = -x;
			yv = -yv;
		end else if (z < -26353590) begin
			z += 52707179;
			x = -x;
			yv = -yv;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(yv, i);
			if (z >= 0) begin
				x -= ys;
				yv += xs;
				z -= atan_z_tab[i];
			end else begin
				x += ys;
				yv -= xs;
				z += atan_z_tab[i];
			end
		end
		c.vx = VEL_W'(clip(floor_shift(x + 32768, 16), -8192, 8191));
		c.vy = VEL_W'(clip(floor_shift(yv + 32768, 16), -8192, 8191));
		c.yaw = ANG_W'(yaw);
		c.yr = YR_W'(rate);
		c.rej = rej;
		c.cv = r.dv;
		return c;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int k;
		k = $urandom_range(99);
		r.fwd = k < 70 ? VEL_W'($urandom_range(0, 8192) - 4096) : VEL_W'($urandom);
		r.lat = k < 70 ? VEL_W'($urandom_range(0, 4000) - 2000) : VEL_W'($urandom);
		r.yr = k < 75 ? YR_W'($urandom_range(0, 16384) - 8192) : YR_W'($urandom);
		r.meas = k < 90 ? ANG_W'($urandom_range(0, 51472) - 25736) : ANG_W'($urandom);
		r.init = k < 90 ? ANG_W'($urandom_range(0, 51472) - 25736) : ANG_W'($urandom);
		r.dv = 1'($urandom);
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver side: stall, hold-off and checking
	always @(posedge clk) begin
		cmd_out.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		if (cmd_out.valid && cmd_out.ready) begin
			if (expected_commands.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected command %h", command_t'({cmd_out.world_vel_x,
						cmd_out.world_vel_y, cmd_out.yaw_command, cmd_out.yaw_rate_command,
						cmd_out.target_rejected, cmd_out.command_valid}));
			end else begin
				command_t e, a;
				e = expected_commands.pop_front();
				a = {cmd_out.world_vel_x, cmd_out.world_vel_y, cmd_out.yaw_command,
					cmd_out.yaw_rate_command, cmd_out.target_rejected, cmd_out.command_valid};
				if (a !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("command mismatch: vx %0d/%0d vy %0d/%0d yaw %0d/%0d yr %0d/%0d rej %b/%b cv %b/%b",
							e.vx, a.vx, e.vy, a.vy, e.yaw, a.yaw, e.yr, a.yr,
							e.rej, a.rej, e.cv, a.cv);
				end
			end
		end
	end

	// watchdog on handshakes
	always @(posedge clk) begin
		if ((cmd_in.valid && cmd_in.ready) || (cmd_out.valid && cmd_out.ready) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("heading_velocity_command_limiter_top_test failed");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= PADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_MAX_LINEAR_STEP:   lin_step = val & 32'h1FFF;
			REG_MAX_YAW_RATE_STEP: rate_step = val & 32'h3FFF;
			default:               period = val & 32'hFFFF;
		endcase
	endtask

	// valid stays high after an accept until the next idle cycle or the drain drops it
	task automatic send_request(request_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_in.valid <= 0;
			@(posedge clk);
		end
		cmd_in.valid <= 1;
		{cmd_in.forward_target, cmd_in.lateral_target, cmd_in.yaw_rate_target,
			cmd_in.measured_yaw, cmd_in.initial_yaw, cmd_in.desired_valid} <= r;
		@(posedge clk);
		while (!cmd_in.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		cmd_in.valid <= 0;
		while (expected_commands.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int count);
		request_t r;
		for (int i = 0; i < count; i++) begin
			r = random_request();
			expected_commands.push_back(limit_command(r));
			send_request(r);
		end
	endtask

	stim_row_t directed[$];

	function automatic stim_row_t row(request_t r, logic known, command_t c);
		stim_row_t s;
		s.req = r;
		s.known = known;
		s.cmd = c;
		return s;
	endfunction

	initial begin
		command_t pred;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		cmd_in.valid = 0;
		{cmd_in.forward_target, cmd_in.lateral_target, cmd_in.yaw_rate_target,
			cmd_in.measured_yaw, cmd_in.initial_yaw, cmd_in.desired_valid} = '0;
		cmd_out.ready = 0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		lin_step = 8;
		rate_step = 16;
		period = 131;
		{held_f, held_l, held_r, vel_f, vel_l, rate, yaw} = '0;
		yaw_ready = 0;
		repeat (10) @(posedge clk);
		arst_n = 1;

		// first tick loads zero yaw and zero velocity: zero velocity, yaw and rate output
		directed.push_back(row({14'sd0, 14'sd0, 15'sd0, 16'sd0, 16'sd0, 1'b1}, 1,
			{14'sd0, 14'sd0, 16'sd0, 15'sd0, 1'b0, 1'b1}));
		// overspeed target refused, held target stays zero
		directed.push_back(row({14'sd8191, 14'sd0, 15'sd0, 16'sd0, 16'sd0, 1'b0}, 1,
			{14'sd0, 14'sd0, 16'sd0, 15'sd0, 1'b1, 1'b0}));
		// yaw rate beyond limit refused
		directed.push_back(row({14'sd0, 14'sd0, 15'h4000, 16'sd0, 16'sd0, 1'b1}, 1,
			{14'sd0, 14'sd0, 16'sd0, 15'sd0, 1'b1, 1'b1}));
		directed.push_back(row({14'h2000, 14'h2000, 15'sd16383, 16'sd0, 16'sd0, 1'b1},
			1, {14'sd0, 14'sd0, 16'sd0, 15'sd0, 1'b1, 1'b1}));
		directed.push_back(row({14'sd4096, 14'sd0, 15'sd8192, 16'sd25736, 16'sd0, 1'b1}, 0, '0));
		directed.push_back(row({14'sd0, -14'sd4096, -15'sd8192, -16'sd25736, 16'sd0, 1'b0}, 0, '0));
		directed.push_back(row({14'sd2896, 14'sd2896, 15'sd100, 16'sd25736, 16'sd0, 1'b1}, 0, '0));
		directed.push_back(row({-14'sd4096, 14'sd0, 15'sd8192, 16'sd32767, 16'h8000, 1'b1},
			0, '0));
		directed.push_back(row({14'sd3000, -14'sd2000, -15'sd5000, 16'h8000, 16'sd32767,
			1'b0}, 0, '0));
		directed.push_back(row({14'sd1, -14'sd1, 15'sd1, 16'sd12868, 16'sd0, 1'b1}, 0, '0));

		foreach (directed[i]) begin
			pred = limit_command(directed[i].req);
			expected_commands.push_back(directed[i].known ? directed[i].cmd : pred);
			send_request(directed[i].req);
		end
		drain();

		// large steps and the largest tick period, with yaw sweeping
		write_reg(REG_MAX_LINEAR_STEP, 4096);
		write_reg(REG_MAX_YAW_RATE_STEP, 8192);
		write_reg(REG_TICK_PERIOD, 65535);
		run_random(300);
		drain();

		send_idle_pct = 58;
		write_reg(REG_MAX_LINEAR_STEP, 0);
		write_reg(REG_MAX_YAW_RATE_STEP, 0);
		write_reg(REG_TICK_PERIOD, 1);
		run_random(200);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 58;
		write_reg(REG_MAX_LINEAR_STEP, 8191);
		write_reg(REG_MAX_YAW_RATE_STEP, 16383);
		write_reg(REG_TICK_PERIOD, 0);
		run_random(300);
		drain();

		send_idle_pct = 29;
		recv_stall_pct = 29;
		write_reg(REG_MAX_LINEAR_STEP, $urandom_range(1, 300));
		write_reg(REG_MAX_YAW_RATE_STEP, $urandom_range(1, 600));
		write_reg(REG_TICK_PERIOD, $urandom_range(1, 65535));
		fork
			run_random(450);
			begin
				repeat (50) @(posedge clk);
				hold_off = 1;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
		join
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(REG_MAX_LINEAR_STEP, 8);
		write_reg(REG_MAX_YAW_RATE_STEP, 16);
		write_reg(REG_TICK_PERIOD, 131);
		run_random(450);
		drain();

		if (mismatches == 0 && expected_commands.size() == 0)
			$display("heading_velocity_command_limiter_top_test passed");
		else
			$display("heading_velocity_command_limiter_top_test failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/hvcl_pkg.sv
hw/rtl/hvcl_if.sv
hw/rtl/hvcl_iter.sv
hw/rtl/hvcl_cordic.sv
hw/rtl/heading_velocity_command_limiter_top.sv
tb/heading_velocity_command_limiter_top_test.sv
